// File: hw/rtl/pasl_pkg.sv
// Shared types and constants for the pairing address slot table.
package pasl_pkg;

  localparam int unsigned CmdW    = 4;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned AddrW   = 48;
  localparam int unsigned CharIdxW = 5;
  localparam int unsigned CharW   = 8;
  localparam int unsigned StatusW = 2;

  typedef enum logic [CmdW-1:0] {
    CmdAssign    = 4'd0,
    CmdSetEntry  = 4'd1,
    CmdForget    = 4'd2,
    CmdWipe      = 4'd3,
    CmdFindOwner = 4'd4,
    CmdReadEntry = 4'd5,
    CmdClrLabel  = 4'd6,
    CmdWrChar    = 4'd7,
    CmdRdChar    = 4'd8
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk      = 2'd0,
    StatusBadSlot = 2'd1,
    StatusBadChar = 2'd2
  } status_e;

  localparam logic [CharW-1:0] CharPrintLo = 8'h20;
  localparam logic [CharW-1:0] CharPrintHi = 8'h7F;
  localparam logic [CharW-1:0] CharSubst   = 8'h5F; // '_'

endpackage

// File: hw/rtl/pairing_address_slot_table.sv
// Pairing address slot table: slot addresses, occupied marks and label store.
//
// Usage: one command request enters on the in_ channel (cmd, slot, address,
// char_index, char_value) and gives exactly one result on the out_ channel
// (status, found, owner_slot, occupied_out, address_out, char_out, any_empty).
// For each request the accept cycle issues the read of the label memory, and
// the next cycle evaluates the command, updates the state and loads the
// output register. A new request is not taken while one is being evaluated,
// as the read of the label memory is registered.
// Addresses and occupied marks sit in flops so find owner compares every slot
// in parallel. Label characters live in a synchronous RAM of
// NUM_SLOTS*LABEL_LEN bytes; a valid bit per character (cleared at reset and
// by clear label, set entry, forget, wipe or an address change on assign)
// makes an unwritten character read as zero, so no clearing pass is needed.
// Reset empties the table and drops any request in flight.
// While the receiver stalls the result is held in the output register and
// in_ready_o stays low, so nothing is lost or overtaken.
module pairing_address_slot_table #(
  parameter int unsigned NUM_SLOTS = 4,
  parameter int unsigned LABEL_LEN = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [pasl_pkg::CmdW-1:0]       cmd_i,
  input  logic [pasl_pkg::SlotW-1:0]      slot_i,
  input  logic [pasl_pkg::AddrW-1:0]      address_i,
  input  logic [pasl_pkg::CharIdxW-1:0]   char_index_i,
  input  logic [pasl_pkg::CharW-1:0]      char_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pasl_pkg::StatusW-1:0]    status_o,
  output logic                            found_o,
  output logic [pasl_pkg::SlotW-1:0]      owner_slot_o,
  output logic                            occupied_out_o,
  output logic [pasl_pkg::AddrW-1:0]      address_out_o,
  output logic [pasl_pkg::CharW-1:0]      char_out_o,
  output logic                            any_empty_o
);
  import pasl_pkg::*;

  localparam int unsigned Depth = NUM_SLOTS * LABEL_LEN;
  localparam int unsigned MemAw = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned SIdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // slot flops
  logic [AddrW-1:0]     slot_addr_q [NUM_SLOTS];
  logic [AddrW-1:0]     slot_addr_d [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] occ_q, occ_d;
  logic [Depth-1:0]     lbl_vld_q, lbl_vld_d;

  // label RAM
  logic [CharW-1:0]     lbl_mem [Depth];
  logic [CharW-1:0]     rdata_q;
  logic                 mem_we;
  logic [CharW-1:0]     mem_wdata;

  // request held for the evaluate cycle
  logic                 busy_q;
  logic [CmdW-1:0]      cmd_q;
  logic [SlotW-1:0]     slot_q;
  logic [AddrW-1:0]     addr_q;
  logic [CharIdxW-1:0]  ci_q;
  logic [CharW-1:0]     cv_q;
  logic [MemAw-1:0]     flat_q;
  logic [MemAw-1:0]     flat_in;

  // output register
  logic                 out_valid_q;
  logic [StatusW-1:0]   status_q, status_d;
  logic                 found_q, found_d;
  logic [SlotW-1:0]     owner_q, owner_d;
  logic                 occ_out_q, occ_out_d;
  logic [AddrW-1:0]     aout_q, aout_d;
  logic [CharW-1:0]     cout_q, cout_d;
  logic                 any_empty_q;

  logic                 in_acc;
  logic                 slot_ok, ci_ok, uses_slot, is_char_cmd;
  logic [SIdxW-1:0]     sidx;

  function automatic logic [CharW-1:0] sanitize(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    if (c == '0) r = '0;
    else if (c >= CharPrintLo && c < CharPrintHi) r = c;
    else r = CharSubst;
    return r;
  endfunction

  assign in_ready_o = !busy_q && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign flat_in    = MemAw'(int'(slot_i) * LABEL_LEN + int'(char_index_i));

  assign slot_ok     = 32'(slot_q) < NUM_SLOTS;
  assign ci_ok       = 32'(ci_q) < LABEL_LEN;
  assign sidx        = SIdxW'(slot_q);
  assign is_char_cmd = (cmd_q == CmdWrChar) || (cmd_q == CmdRdChar);
  assign uses_slot   = (cmd_q <= CmdForget) ||
                       ((cmd_q >= CmdReadEntry) && (cmd_q <= CmdRdChar));

  always_comb begin
    slot_addr_d = slot_addr_q;
    occ_d       = occ_q;
    lbl_vld_d   = lbl_vld_q;
    mem_we      = 1'b0;
    mem_wdata   = sanitize(cv_q);
    status_d    = StatusOk;
    found_d     = 1'b0;
    owner_d     = '0;
    occ_out_d   = 1'b0;
    aout_d      = '0;
    cout_d      = '0;
    if (uses_slot && !slot_ok) begin
      status_d = StatusBadSlot;
    end else if (is_char_cmd && !ci_ok) begin
      status_d = StatusBadChar;
    end else begin
      unique case (cmd_e'(cmd_q))
        CmdAssign: begin
          if (slot_addr_q[sidx] != addr_q) begin
            for (int j = 0; j < LABEL_LEN; j++) begin
              lbl_vld_d[MemAw'(int'(sidx) * LABEL_LEN + j)] = 1'b0;
            end
          end
          slot_addr_d[sidx] = addr_q;
          occ_d[sidx]       = 1'b1;
        end
        CmdSetEntry: begin
          for (int j = 0; j < LABEL_LEN; j++) begin
            lbl_vld_d[MemAw'(int'(sidx) * LABEL_LEN + j)] = 1'b0;
          end
          slot_addr_d[sidx] = addr_q;
          occ_d[sidx]       = 1'b1;
        end
        CmdForget: begin
          for (int j = 0; j < LABEL_LEN; j++) begin
            lbl_vld_d[MemAw'(int'(sidx) * LABEL_LEN + j)] = 1'b0;
          end
          slot_addr_d[sidx] = '0;
          occ_d[sidx]       = 1'b0;
        end
        CmdWipe: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_addr_d[i] = '0;
          end
          occ_d     = '0;
          lbl_vld_d = '0;
        end
        CmdFindOwner: begin
          // scan downwards so the lowest match wins
          for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (occ_q[i] && slot_addr_q[i] == addr_q) begin
              found_d = 1'b1;
              owner_d = SlotW'(i);
            end
          end
        end
        CmdReadEntry: begin
          occ_out_d = occ_q[sidx];
          aout_d    = slot_addr_q[sidx];
        end
        CmdClrLabel: begin
          for (int j = 0; j < LABEL_LEN; j++) begin
            lbl_vld_d[MemAw'(int'(sidx) * LABEL_LEN + j)] = 1'b0;
          end
        end
        CmdWrChar: begin
          mem_we            = 1'b1;
          lbl_vld_d[flat_q] = 1'b1;
        end
        CmdRdChar: begin
          cout_d = lbl_vld_q[flat_q] ? rdata_q : '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && mem_we) lbl_mem[flat_q] <= mem_wdata;
    if (in_acc) rdata_q <= lbl_mem[flat_in];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= cmd_i;
      slot_q <= slot_i;
      addr_q <= address_i;
      ci_q   <= char_index_i;
      cv_q   <= char_value_i;
      flat_q <= flat_in;
    end
    if (busy_q) begin
      status_q    <= status_d;
      found_q     <= found_d;
      owner_q     <= owner_d;
      occ_out_q   <= occ_out_d;
      aout_q      <= aout_d;
      cout_q      <= cout_d;
      any_empty_q <= ~&occ_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      occ_q       <= '0;
      lbl_vld_q   <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_addr_q[i] <= '0;
      end
    end else begin
      busy_q <= in_acc;
      if (busy_q) begin
        out_valid_q <= 1'b1;
        occ_q       <= occ_d;
        lbl_vld_q   <= lbl_vld_d;
        slot_addr_q <= slot_addr_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign found_o        = found_q;
  assign owner_slot_o   = owner_q;
  assign occupied_out_o = occ_out_q;
  assign address_out_o  = aout_q;
  assign char_out_o     = cout_q;
  assign any_empty_o    = any_empty_q;

endmodule
